// ===== rtl/timed_threshold_condition_qualifier_defines.svh =====
// Assertion macros for the timed threshold condition qualifier
`ifndef TIMED_THRESHOLD_CONDITION_QUALIFIER_DEFINES_SVH
`define TIMED_THRESHOLD_CONDITION_QUALIFIER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TTCQ_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TTCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ttcq_pkg.sv =====
// Shared types and constants for the timed threshold condition qualifier
package ttcq_pkg;

    localparam int MAX_CONDITIONS    = 2;
    localparam int NUM_SAMPLE_FIELDS = 4;
    localparam int SEL_W             = $clog2(NUM_SAMPLE_FIELDS);
    localparam int TIME_W            = 48;
    localparam int HOLD_W            = 32;
    localparam int VALUE_W           = 32;
    localparam int COUNT_W           = 3;
    localparam int CFG_INDEX_W       = 4;

    localparam logic [HOLD_W-1:0] HOLD_RESET_MS = HOLD_W'(100);

    // comparison operators
    localparam logic [2:0] OP_LT = 3'd0;
    localparam logic [2:0] OP_LE = 3'd1;
    localparam logic [2:0] OP_EQ = 3'd2;
    localparam logic [2:0] OP_GT = 3'd3;
    localparam logic [2:0] OP_GE = 3'd4;
    localparam logic [2:0] OP_NE = 3'd5;

    // register slot within one condition
    localparam logic [1:0] REG_INDEX     = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_OPERATOR  = 2'd2;
    localparam logic [1:0] REG_HOLD      = 2'd3;

    // input function codes
    localparam logic FUNC_TICK      = 1'b0;
    localparam logic FUNC_RESET_ALL = 1'b1;

    typedef logic signed [VALUE_W-1:0] sample_t;

    typedef struct packed {
        logic [7:0]                index;
        logic signed [VALUE_W-1:0] threshold;
        logic [2:0]                operator;
        logic [HOLD_W-1:0]         hold_ms;
    } cond_cfg_t;

    typedef struct packed {
        logic               func;
        logic [TIME_W-1:0]  now_ms;
        logic               active;
        logic [COUNT_W-1:0] count;
    } tick_t;

endpackage

// ===== rtl/ttcq_cfg.sv =====
// Configuration register file for both conditions
module ttcq_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [ttcq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data,
    output ttcq_pkg::cond_cfg_t                 cfg [ttcq_pkg::MAX_CONDITIONS]
);
    import ttcq_pkg::*;

    cond_cfg_t cfg_reg  [MAX_CONDITIONS];
    cond_cfg_t cfg_next [MAX_CONDITIONS];

    always_comb
    begin
        for (int c = 0; c < MAX_CONDITIONS; c++)
        begin
            cfg_next[c] = cfg_reg[c];
            if (cfg_valid && !cfg_index[3] && (cfg_index[2] == c[0]))
            begin
                case (cfg_index[1:0])
                    REG_INDEX:     cfg_next[c].index     = cfg_data[7:0];
                    REG_THRESHOLD: cfg_next[c].threshold = cfg_data;
                    REG_OPERATOR:  cfg_next[c].operator  = cfg_data[2:0];
                    REG_HOLD:      cfg_next[c].hold_ms   = cfg_data;
                    default:       cfg_next[c]           = cfg_reg[c];
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CONDITIONS; c++)
            begin
                cfg_reg[c].index     <= '0;
                cfg_reg[c].threshold <= '0;
                cfg_reg[c].operator  <= OP_EQ;
                cfg_reg[c].hold_ms   <= HOLD_RESET_MS;
            end
        end
        else
        begin
            for (int c = 0; c < MAX_CONDITIONS; c++)
                cfg_reg[c] <= cfg_next[c];
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ttcq_cond.sv =====
// One condition: compare, hold timer and met state
module ttcq_cond (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd,
    input  ttcq_pkg::tick_t       tick,
    input  ttcq_pkg::sample_t     samples [ttcq_pkg::NUM_SAMPLE_FIELDS],
    input  ttcq_pkg::cond_cfg_t   cfg,
    output logic                  met
);
    import ttcq_pkg::*;

    logic              met_flag_reg, met_flag_next;
    logic [TIME_W-1:0] hold_start_reg, hold_start_next;
    logic              prev_cmp_reg, prev_cmp_next;
    logic              pending_reg, pending_next;

    sample_t           value;
    logic              cmp;
    logic              met_c, prev_c;
    logic [TIME_W-1:0] start_c, start_h;
    logic [TIME_W:0]   deadline;
    logic              expired;

    assign value = samples[cfg.index[SEL_W-1:0]];

    always_comb
    begin
        case (cfg.operator)
            OP_LT:   cmp = cfg.threshold <  value;
            OP_LE:   cmp = cfg.threshold <= value;
            OP_EQ:   cmp = cfg.threshold == value;
            OP_GT:   cmp = cfg.threshold >  value;
            OP_GE:   cmp = cfg.threshold >= value;
            OP_NE:   cmp = cfg.threshold != value;
            default: cmp = 1'b0;
        endcase
    end

    // pending reset is applied first, then the normal evaluation
    assign met_c    = pending_reg ? 1'b0 : met_flag_reg;
    assign prev_c   = pending_reg ? 1'b0 : prev_cmp_reg;
    assign start_c  = pending_reg ? tick.now_ms : hold_start_reg;
    assign start_h  = prev_c ? start_c : tick.now_ms;
    assign deadline = {1'b0, start_h} + {{(TIME_W + 1 - HOLD_W){1'b0}}, cfg.hold_ms};
    assign expired  = {1'b0, tick.now_ms} > deadline;

    always_comb
    begin
        met_flag_next   = met_flag_reg;
        hold_start_next = hold_start_reg;
        prev_cmp_next   = prev_cmp_reg;
        pending_next    = pending_reg;
        if (tick.func == FUNC_RESET_ALL)
        begin
            pending_next = 1'b1;
        end
        else if (tick.active)
        begin
            pending_next = 1'b0;
            if (cfg.index < {{(8 - COUNT_W){1'b0}}, tick.count})
            begin
                prev_cmp_next = cmp;
                if (!cmp)
                begin
                    met_flag_next   = 1'b0;
                    hold_start_next = tick.now_ms;
                end
                else
                begin
                    met_flag_next   = met_c | expired;
                    hold_start_next = start_h;
                end
            end
            else
            begin
                met_flag_next   = met_c;
                hold_start_next = start_c;
                prev_cmp_next   = prev_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            met_flag_reg   <= 1'b0;
            hold_start_reg <= '0;
            prev_cmp_reg   <= 1'b0;
            pending_reg    <= 1'b0;
        end
        else if (upd)
        begin
            met_flag_reg   <= met_flag_next;
            hold_start_reg <= hold_start_next;
            prev_cmp_reg   <= prev_cmp_next;
            pending_reg    <= pending_next;
        end
    end

    assign met = met_flag_next & ~pending_next;

endmodule

// ===== rtl/timed_threshold_condition_qualifier.sv =====
// Timed threshold condition qualifier, top level. Each input word is taken
// into an input register, evaluated against both conditions and written, with
// the updated hold state, into the result register once that register is free
// (result register empty or out_stall low): one word per clock cycle sustained
// while out_stall is low. The rate is set by the update of each condition's
// hold state, done combinationally (one signed 32-bit compare and one 49-bit
// add-and-compare). Configuration writes are taken at any time but must only
// be issued while no word is in flight.
module timed_threshold_condition_qualifier #(
    parameter int NUM_VALUES     = 4,
    parameter int NUM_CONDITIONS = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [47:0]                         now_ms,
    input  logic                                device_active,
    input  logic [2:0]                          value_count,
    input  logic signed [31:0]                  sample_a,
    input  logic signed [31:0]                  sample_b,
    input  logic signed [31:0]                  sample_c,
    input  logic signed [31:0]                  sample_d,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                met_0,
    output logic                                met_1,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ttcq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data
);
    import ttcq_pkg::*;

    `include "timed_threshold_condition_qualifier_defines.svh"

    localparam int LIMIT = (NUM_VALUES < NUM_SAMPLE_FIELDS) ? NUM_VALUES : NUM_SAMPLE_FIELDS;

    logic      s1_valid_reg, s1_valid_next;
    tick_t     s1_tick_reg;
    sample_t   s1_samples_reg [NUM_SAMPLE_FIELDS];
    logic      out_valid_reg, out_valid_next;
    logic      met_reg [MAX_CONDITIONS];
    logic      met_next [MAX_CONDITIONS];

    logic      in_accept;
    logic      out_free;
    logic      adv;
    tick_t     tick_in;
    cond_cfg_t cfg [MAX_CONDITIONS];

    assign out_free  = !out_valid_reg || !out_stall;
    assign adv       = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        tick_in.func   = func;
        tick_in.now_ms = now_ms;
        tick_in.active = device_active;
        tick_in.count  = (value_count > COUNT_W'(LIMIT)) ? COUNT_W'(LIMIT) : value_count;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (out_free)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_tick_reg       <= tick_in;
            s1_samples_reg[0] <= sample_a;
            s1_samples_reg[1] <= sample_b;
            s1_samples_reg[2] <= sample_c;
            s1_samples_reg[3] <= sample_d;
        end
        if (adv)
        begin
            for (int c = 0; c < MAX_CONDITIONS; c++)
                met_reg[c] <= met_next[c];
        end
    end

    ttcq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    for (genvar g = 0; g < MAX_CONDITIONS; g++)
    begin : g_cond
        if (g < NUM_CONDITIONS)
        begin : g_used
            ttcq_cond u_cond (
                .clk     (clk),
                .rst_n   (rst_n),
                .upd     (adv),
                .tick    (s1_tick_reg),
                .samples (s1_samples_reg),
                .cfg     (cfg[g]),
                .met     (met_next[g])
            );
        end
        else
        begin : g_unused
            assign met_next[g] = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign met_0     = met_reg[0];
    assign met_1     = met_reg[1];

    `TTCQ_ASSERT_NEXT(a_advance_fills_output, adv, out_valid_reg, "result register not loaded")
    `TTCQ_ASSERT_NEXT(a_reset_all_reads_zero, adv && (s1_tick_reg.func == FUNC_RESET_ALL), !met_0 && !met_1, "reset-all word reported a met condition")
    `TTCQ_ASSERT(a_empty_stage_never_stalls, !s1_valid_reg, !in_stall, "input stalled with empty input register")

endmodule

// ===== tb/timed_threshold_condition_qualifier_tb.sv =====
// Self-checking testbench for the timed threshold condition qualifier
module timed_threshold_condition_qualifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttcq_pkg::*;

    localparam int VALUES = 4;
    localparam int CONDS  = 2;

    typedef struct {
        bit m0;
        bit m1;
    } met_pair_t;

    // tracks condition state and the met flags still owed by the block
    class met_scoreboard;
        logic [7:0]          idx   [CONDS];
        logic signed [31:0]  thr   [CONDS];
        logic [2:0]          op    [CONDS];
        logic [HOLD_W-1:0]   hold  [CONDS];
        bit                  met   [CONDS];
        logic [TIME_W-1:0]   start [CONDS];
        bit                  prev  [CONDS];
        bit                  pend  [CONDS];
        met_pair_t           met_expected [$];
        int                  errors;

        function new();
            for (int c = 0; c < CONDS; c++)
            begin
                idx[c]   = '0;
                thr[c]   = '0;
                op[c]    = OP_EQ;
                hold[c]  = HOLD_RESET_MS;
                met[c]   = 1'b0;
                start[c] = '0;
                prev[c]  = 1'b0;
                pend[c]  = 1'b0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] ri, logic [31:0] d);
            int c;
            if (ri >= 4 * CONDS)
                return;
            c = ri[2];
            case (ri[1:0])
                REG_INDEX:     idx[c]  = d[7:0];
                REG_THRESHOLD: thr[c]  = d;
                REG_OPERATOR:  op[c]   = d[2:0];
                default:       hold[c] = d;
            endcase
        endfunction

        function bit holds(logic signed [31:0] t, logic signed [31:0] v, logic [2:0] code);
            case (code)
                OP_LT:   return t < v;
                OP_LE:   return t <= v;
                OP_EQ:   return t == v;
                OP_GT:   return t > v;
                OP_GE:   return t >= v;
                OP_NE:   return t != v;
                default: return 1'b0;
            endcase
        endfunction

        function void note_tick(logic f, logic [TIME_W-1:0] t, logic act,
                                logic [COUNT_W-1:0] cnt, sample_t s [4]);
            logic [COUNT_W-1:0] usable;
            logic [TIME_W:0]    deadline;
            bit                 cmp;
            met_pair_t          e;
            usable = (cnt > VALUES) ? COUNT_W'(VALUES) : cnt;
            if (f == FUNC_RESET_ALL)
            begin
                for (int c = 0; c < CONDS; c++)
                    pend[c] = 1'b1;
            end
            else if (act)
            begin
                for (int c = 0; c < CONDS; c++)
                begin
                    if (pend[c])
                    begin
                        met[c]   = 1'b0;
                        start[c] = t;
                        prev[c]  = 1'b0;
                        pend[c]  = 1'b0;
                    end
                    if (idx[c] >= usable)
                        continue;
                    cmp = holds(thr[c], s[idx[c][1:0]], op[c]);
                    if (!cmp)
                    begin
                        met[c]   = 1'b0;
                        start[c] = t;
                    end
                    else
                    begin
                        if (!prev[c])
                            start[c] = t;
                        deadline = {1'b0, start[c]} + {17'd0, hold[c]};
                        if (!met[c] && {1'b0, t} > deadline)
                            met[c] = 1'b1;
                    end
                    prev[c] = cmp;
                end
            end
            e.m0 = met[0] && !pend[0];
            e.m1 = met[1] && !pend[1];
            met_expected = {met_expected, e};
        endfunction

        function void check_met(bit m0, bit m1);
            met_pair_t e;
            if (met_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word met_0=%0b met_1=%0b", $time, m0, m1);
                return;
            end
            e = met_expected.pop_front();
            if (e.m0 !== m0)
            begin
                errors++;
                $display("%0t: met_0 expected %0b, got %0b", $time, e.m0, m0);
            end
            if (e.m1 !== m1)
            begin
                errors++;
                $display("%0t: met_1 expected %0b, got %0b", $time, e.m1, m1);
            end
        endfunction

        function int outstanding();
            return met_expected.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   func;
    logic [47:0]            now_ms;
    logic                   device_active;
    logic [2:0]             value_count;
    logic signed [31:0]     sample_a;
    logic signed [31:0]     sample_b;
    logic signed [31:0]     sample_c;
    logic signed [31:0]     sample_d;
    logic                   out_valid;
    logic                   out_stall;
    logic                   met_0;
    logic                   met_1;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    met_scoreboard met_sb = new();
    bit            steady = 1'b0;
    sample_t       cond_thr [CONDS];

    timed_threshold_condition_qualifier #(
        .NUM_VALUES     (VALUES),
        .NUM_CONDITIONS (CONDS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .now_ms        (now_ms),
        .device_active (device_active),
        .value_count   (value_count),
        .sample_a      (sample_a),
        .sample_b      (sample_b),
        .sample_c      (sample_c),
        .sample_d      (sample_d),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .met_0         (met_0),
        .met_1         (met_1),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 14);

    // result first, so a result word never matches a word taken on the same edge
    always @(posedge clk)
    begin
        sample_t smp [4];
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                met_sb.check_met(met_0, met_1);
            if (in_valid && !in_stall)
            begin
                smp = '{sample_a, sample_b, sample_c, sample_d};
                met_sb.note_tick(func, now_ms, device_active, value_count, smp);
            end
        end
    end

    task automatic send_word(input logic f, input logic [47:0] t, input logic act,
                             input logic [2:0] cnt, input sample_t a, input sample_t b,
                             input sample_t c, input sample_t d);
        while (!steady && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        now_ms        <= t;
        device_active <= act;
        value_count   <= cnt;
        sample_a      <= a;
        sample_b      <= b;
        sample_c      <= c;
        sample_d      <= d;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (met_sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_reg(input logic [CFG_INDEX_W-1:0] ri, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        met_sb.write_reg(ri, d);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_condition(input int c, input logic [7:0] ix, input sample_t th,
                                 input logic [2:0] code, input logic [31:0] hms);
        program_reg(CFG_INDEX_W'(4 * c) + REG_INDEX, {24'd0, ix});
        program_reg(CFG_INDEX_W'(4 * c) + REG_THRESHOLD, th);
        program_reg(CFG_INDEX_W'(4 * c) + REG_OPERATOR, {29'd0, code});
        program_reg(CFG_INDEX_W'(4 * c) + REG_HOLD, hms);
        cond_thr[c] = th;
    endtask

    function automatic sample_t pick_value();
        sample_t near;
        near = cond_thr[$urandom_range(0, CONDS - 1)];
        case ($urandom_range(0, 7))
            0, 1:    return near;
            2:       return near + 1;
            3:       return near - 1;
            4:       return 32'sh7FFF_FFFF;
            5:       return 32'sh8000_0000;
            6:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_condition(input int c);
        logic [7:0]  ix;
        sample_t     th;
        logic [31:0] hms;
        int          r;
        ix = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 255))
                                         : 8'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0:       th = '0;
            1:       th = 32'sh7FFF_FFFF;
            2:       th = 32'sh8000_0000;
            3:       th = $signed(32'($urandom_range(0, 20)) - 32'sd10) <<< 16;
            default: th = $urandom;
        endcase
        r = $urandom_range(0, 99);
        if (r < 8)
            hms = 32'hFFFF_FFFF;
        else if (r < 16)
            hms = '0;
        else if (r < 21)
            hms = $urandom;
        else
            hms = $urandom_range(1, 60);
        set_condition(c, ix, th, 3'($urandom_range(0, 7)), hms);
    endtask

    initial
    begin
        logic [47:0] t;
        sample_t     cur [4];
        logic        f;
        logic        act;
        logic [2:0]  cnt;
        int          r;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        func          <= FUNC_TICK;
        now_ms        <= '0;
        device_active <= 1'b0;
        value_count   <= '0;
        sample_a      <= '0;
        sample_b      <= '0;
        sample_c      <= '0;
        sample_d      <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        cond_thr      = '{default: '0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: watch sample 0 for equality with zero, 100 ms hold
        send_word(FUNC_TICK, 48'd0, 1'b1, 3'd4, 0, 1, 2, 3);
        send_word(FUNC_TICK, 48'd100, 1'b1, 3'd4, 0, 1, 2, 3);
        send_word(FUNC_TICK, 48'd101, 1'b1, 3'd4, 0, 1, 2, 3);
        send_word(FUNC_TICK, 48'd500, 1'b0, 3'd4, 5, 1, 2, 3);
        send_word(FUNC_RESET_ALL, 48'd550, 1'b1, 3'd4, 0, 0, 0, 0);
        send_word(FUNC_TICK, 48'd560, 1'b0, 3'd4, 0, 0, 0, 0);
        send_word(FUNC_TICK, 48'd600, 1'b1, 3'd4, 0, 0, 0, 0);
        send_word(FUNC_TICK, 48'd701, 1'b1, 3'd7, 0, 0, 0, 0);
        send_word(FUNC_TICK, 48'd702, 1'b1, 3'd0, 9, 9, 9, 9);
        send_word(FUNC_TICK, 48'd703, 1'b1, 3'd4, 7, 0, 0, 0);
        settle();

        // extremes of index, threshold and hold; writes past the register list
        set_condition(0, 8'd3, 32'sh8000_0000, OP_LT, 32'd0);
        set_condition(1, 8'd255, 32'sh7FFF_FFFF, OP_GE, 32'hFFFF_FFFF);
        program_reg(4'd8, $urandom);
        program_reg(4'd15, 32'hFFFF_FFFF);
        t = 48'hFFFF_FFFF_FF00;
        send_word(FUNC_TICK, t, 1'b1, 3'd4, -1, -1, -1, 32'sh8000_0000);
        send_word(FUNC_TICK, t, 1'b1, 3'd4, -1, -1, -1, 32'sh7FFF_FFFF);
        send_word(FUNC_TICK, t + 1, 1'b1, 3'd4, -1, -1, -1, 32'sh7FFF_FFFF);
        send_word(FUNC_TICK, 48'hFFFF_FFFF_FFFF, 1'b1, 3'd3, 0, 0, 0, 0);
        settle();

        set_condition(0, 8'd1, 32'sh0005_0000, OP_LE, 32'd2);
        set_condition(1, 8'd2, -32'sd3, OP_GT, 32'd0);
        send_word(FUNC_TICK, 48'd10, 1'b1, 3'd4, 0, 32'sh0005_0000, -4, 0);
        send_word(FUNC_TICK, 48'd13, 1'b1, 3'd4, 0, 32'sh0005_0000, -4, 0);
        settle();
        set_condition(0, 8'd0, 32'sd17, OP_NE, 32'd1);
        set_condition(1, 8'd1, 32'sd17, 3'd6, 32'd0);
        send_word(FUNC_TICK, 48'd20, 1'b1, 3'd4, 4, 17, 0, 0);
        send_word(FUNC_TICK, 48'd22, 1'b1, 3'd4, 4, 17, 0, 0);
        settle();
        set_condition(0, 8'd2, 32'sd0, 3'd7, 32'd0);
        send_word(FUNC_TICK, 48'd30, 1'b1, 3'd4, 0, 0, 0, 0);
        send_word(FUNC_TICK, 48'd31, 1'b1, 3'd4, 0, 0, 0, 0);
        settle();

        // random phases: fresh settings each time, sticky samples so holds mature
        t = '0;
        for (int phase = 0; phase < 16; phase++)
        begin
            random_condition(0);
            random_condition(1);
            if ($urandom_range(0, 2) == 0)
                program_reg(CFG_INDEX_W'($urandom_range(8, 15)), $urandom);
            steady = (phase == 5);
            if ($urandom_range(0, 3) == 0)
                t = {16'($urandom), 32'($urandom)};
            else if ($urandom_range(0, 7) == 0)
                t = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3000));
            for (int j = 0; j < 4; j++)
                cur[j] = pick_value();
            for (int k = 0; k < 100; k++)
            begin
                f   = ($urandom_range(0, 99) < 4);
                act = ($urandom_range(0, 9) != 0);
                cnt = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                r   = $urandom_range(0, 99);
                if (r < 3)
                    t = t - 48'($urandom_range(0, 50));
                else if (r < 6)
                    t = t + {16'($urandom), 32'($urandom)};
                else
                    t = t + 48'($urandom_range(0, 25));
                for (int j = 0; j < 4; j++)
                    if ($urandom_range(0, 99) < 25)
                        cur[j] = pick_value();
                send_word(f, t, act, cnt, cur[0], cur[1], cur[2], cur[3]);
            end
            settle();
            steady = 1'b0;
        end

        if (met_sb.outstanding() != 0)
        begin
            met_sb.errors++;
            $display("%0t: %0d result words never arrived", $time, met_sb.outstanding());
        end
        if (met_sb.errors == 0)
            $display("timed_threshold_condition_qualifier verification clean");
        else
            $display("timed_threshold_condition_qualifier verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timed_threshold_condition_qualifier verification failed");
        $finish;
    end

endmodule
